// ----- sv/wmaf_pkg.sv -----
package wmaf_pkg;

  localparam int MaxWidthDef = 1024;
  localparam int MaxWinWDef  = 9;
  localparam int MaxWinHDef  = 5;
  localparam int MaxHeight   = 4096;

  localparam int PixW      = 8;
  localparam int RowW      = 13;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 13;
  localparam int ImgWRegW  = 11;
  localparam int ImgHRegW  = 13;
  localparam int WinWRegW  = 4;
  localparam int WinHRegW  = 3;

  localparam logic [ImgWRegW-1:0] ImgWReset = 11'd640;
  localparam logic [ImgHRegW-1:0] ImgHReset = 13'd480;
  localparam logic [WinWRegW-1:0] WinWReset = 4'd9;
  localparam logic [WinHRegW-1:0] WinHReset = 3'd5;

  localparam logic KindPixel  = 1'b0;
  localparam logic KindFlush  = 1'b1;
  localparam logic ModeAvg    = 1'b0;
  localparam logic ModeMedian = 1'b1;

  typedef enum logic [CfgAddrW-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_WINDOW_WIDTH,
    REG_WINDOW_HEIGHT,
    REG_FILTER_MODE
  } wmaf_cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CMP,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } wmaf_state_e;

  typedef struct packed {
    logic accept;
    logic start_scan;
    logic scan_step;
    logic end_pass;
    logic div_step;
    logic load;
  } wmaf_cmd_t;

  typedef struct packed {
    logic go_pix;
    logic go_flush;
    logic emit_ok;
    logic scan_last;
    logic bit_zero;
    logic mode_avg;
    logic out_free;
  } wmaf_status_t;

endpackage

// ----- sv/window_median_average_filter_core.sv -----
// Window filter on 8-bit gray frames in raster order, with edge pixels replicated at the
// borders; mode 0 gives the truncated mean of the window, mode 1 the element n/2 of the
// sorted window. Results trail the input by (down*width + right) pixels, and one flush
// request per remaining result drains the frame end. Pixels are kept in a line store of
// MAX_WIN_H+1 rows, which needs no clearing after reset. Requests are taken one at a time.
// A result is built by walking the window through the single line-store read port,
// one pixel per cycle: in average mode one walk over the n window pixels, a drain step,
// then an 8-step divide; in median mode one walk and drain per bit of the median; then
// the result waits for the output register to free up.
// A finished result waits in the output register while the next request is accepted.
module window_median_average_filter_core #(
  parameter int MAX_WIDTH = wmaf_pkg::MaxWidthDef,
  parameter int MAX_WIN_W = wmaf_pkg::MaxWinWDef,
  parameter int MAX_WIN_H = wmaf_pkg::MaxWinHDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wmaf_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [wmaf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] gray_value
  input  logic [1:0]                    s_axis_tuser,  // [0] item_kind, [1] frame_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] filtered_value
  output logic                          m_axis_tlast
);
  import wmaf_pkg::*;

  wmaf_cmd_t    cmd;
  wmaf_status_t status;

  wmaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wmaf_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_WIN_W (MAX_WIN_W),
    .MAX_WIN_H (MAX_WIN_H)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .gray_i        (s_axis_tdata),
    .kind_i        (s_axis_tuser[0]),
    .frame_start_i (s_axis_tuser[1]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_value_o   (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );

endmodule

// ----- sv/wmaf_ctrl.sv -----
module wmaf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  wmaf_pkg::wmaf_status_t status_i,
  output wmaf_pkg::wmaf_cmd_t    cmd_o
);
  import wmaf_pkg::*;

  wmaf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status_i.go_flush) begin
          cmd_o.start_scan = 1'b1;
          state_d          = ST_SCAN;
        end else if (status_i.go_pix) begin
          state_d = ST_CMP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CMP: begin
        if (status_i.emit_ok) begin
          cmd_o.start_scan = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read word lands now: close the pass
        cmd_o.end_pass = 1'b1;
        priority if (status_i.mode_avg) begin
          state_d = ST_DIV;
        end else if (status_i.bit_zero) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.bit_zero) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> status_i.out_free) else $error("result loaded into busy output");
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_CHECK) else $error("accepted request not checked");
  a_scan_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_scan |-> (status_i.go_flush || status_i.emit_ok))
    else $error("window scan without a due output");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && status_i.scan_last) |=> state_q == ST_DRAIN)
    else $error("pass end not drained");

endmodule

// ----- sv/wmaf_dp.sv -----
module wmaf_dp #(
  parameter int MAX_WIDTH = wmaf_pkg::MaxWidthDef,
  parameter int MAX_WIN_W = wmaf_pkg::MaxWinWDef,
  parameter int MAX_WIN_H = wmaf_pkg::MaxWinHDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wmaf_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [wmaf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [wmaf_pkg::PixW-1:0]     gray_i,
  input  logic                          kind_i,
  input  logic                          frame_start_i,
  input  wmaf_pkg::wmaf_cmd_t           cmd_i,
  output wmaf_pkg::wmaf_status_t        status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wmaf_pkg::PixW-1:0]     out_value_o,
  output logic                          out_last_o
);
  import wmaf_pkg::*;

  localparam int StoreRows = MAX_WIN_H + 1;
  localparam int SlotW     = $clog2(StoreRows);
  localparam int ColW      = $clog2(MAX_WIDTH + 1);
  localparam int Depth     = StoreRows * MAX_WIDTH;
  localparam int AddrW     = $clog2(Depth);
  localparam int WwW       = $clog2(MAX_WIN_W + 1);
  localparam int WhW       = $clog2(MAX_WIN_H + 1);
  localparam int NMax      = MAX_WIN_W * MAX_WIN_H;
  localparam int NW        = $clog2(NMax + 1);
  localparam int SumW      = PixW + NW;
  localparam int ProdW     = RowW + ColW;
  localparam int LinW      = ProdW + 2;
  localparam int CsW       = ColW + 2;
  localparam int RsW       = RowW + 2;

  // configuration
  logic [ImgWRegW-1:0] img_w_q;
  logic [ImgHRegW-1:0] img_h_q;
  logic [WinWRegW-1:0] win_w_q;
  logic [WinHRegW-1:0] win_h_q;
  logic                mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= ImgWReset;
      img_h_q <= ImgHReset;
      win_w_q <= WinWReset;
      win_h_q <= WinHReset;
      mode_q  <= ModeMedian;
    end else if (cfg_we_i) begin
      case (wmaf_cfg_reg_e'(cfg_addr_i))
        REG_IMAGE_WIDTH:   img_w_q <= cfg_wdata_i[ImgWRegW-1:0];
        REG_IMAGE_HEIGHT:  img_h_q <= cfg_wdata_i[ImgHRegW-1:0];
        REG_WINDOW_WIDTH:  win_w_q <= cfg_wdata_i[WinWRegW-1:0];
        REG_WINDOW_HEIGHT: win_h_q <= cfg_wdata_i[WinHRegW-1:0];
        REG_FILTER_MODE:   mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [ColW-1:0] w_img;
  logic [RowW-1:0] h_img;
  logic [WwW-1:0]  w_win, left, right;
  logic [WhW-1:0]  h_win, up, down;
  logic [NW-1:0]   n_win, kidx;

  always_comb begin
    if (img_w_q == '0) w_img = ColW'(1);
    else if (int'(img_w_q) > MAX_WIDTH) w_img = ColW'(MAX_WIDTH);
    else w_img = ColW'(img_w_q);
    if (img_h_q == '0) h_img = RowW'(1);
    else if (int'(img_h_q) > MaxHeight) h_img = RowW'(MaxHeight);
    else h_img = RowW'(img_h_q);
    if (win_w_q == '0) w_win = WwW'(1);
    else if (int'(win_w_q) > MAX_WIN_W) w_win = WwW'(MAX_WIN_W);
    else w_win = WwW'(win_w_q);
    if (win_h_q == '0) h_win = WhW'(1);
    else if (int'(win_h_q) > MAX_WIN_H) h_win = WhW'(MAX_WIN_H);
    else h_win = WhW'(win_h_q);
  end

  assign left  = w_win >> 1;
  assign right = w_win - WwW'(1) - left;
  assign up    = h_win >> 1;
  assign down  = h_win - WhW'(1) - up;
  assign n_win = NW'(w_win) * NW'(h_win);
  assign kidx  = n_win >> 1;

  // frame position
  logic [ColW-1:0]  in_col_q, out_col_q, kc_q;
  logic [RowW-1:0]  in_row_q, out_row_q, kr_q;
  logic [SlotW-1:0] in_slot_q, out_slot_q;
  logic             active_q, full_q, go_pix_q, go_flush_q;

  logic             is_pix, fs, act_e, full_e, pix_go;
  logic [ColW-1:0]  ic_e;
  logic [RowW-1:0]  ir_e;
  logic [SlotW-1:0] is_e;
  logic [ColW:0]    ic_inc, oc_inc;
  logic [RowW:0]    ir_inc, or_inc;

  assign is_pix = (kind_i == KindPixel);
  assign fs     = is_pix && frame_start_i;
  assign act_e  = fs ? 1'b1 : active_q;
  assign full_e = fs ? 1'b0 : full_q;
  assign ic_e   = fs ? '0 : in_col_q;
  assign ir_e   = fs ? '0 : in_row_q;
  assign is_e   = fs ? '0 : in_slot_q;
  assign pix_go = is_pix && act_e && !full_e;
  assign ic_inc = {1'b0, ic_e} + (ColW+1)'(1);
  assign ir_inc = {1'b0, ir_e} + (RowW+1)'(1);
  assign oc_inc = {1'b0, out_col_q} + (ColW+1)'(1);
  assign or_inc = {1'b0, out_row_q} + (RowW+1)'(1);

  logic emit_last;
  assign emit_last = (out_row_q >= h_img - RowW'(1)) && (out_col_q >= w_img - ColW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      active_q   <= 1'b0;
      full_q     <= 1'b0;
      go_pix_q   <= 1'b0;
      go_flush_q <= 1'b0;
    end else if (cmd_i.accept) begin
      go_pix_q   <= pix_go;
      go_flush_q <= !is_pix && active_q && full_q;
      if (fs) begin
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_slot_q <= '0;
        active_q   <= 1'b1;
      end
      // a frame start always takes the pixel path, which restarts the input position
      if (pix_go) begin
        if (ic_inc >= (ColW+1)'(w_img)) begin
          in_col_q <= '0;
          if (ir_inc >= (RowW+1)'(h_img)) begin
            in_row_q  <= '0;
            in_slot_q <= '0;
            full_q    <= 1'b1;
          end else begin
            in_row_q  <= ir_inc[RowW-1:0];
            in_slot_q <= (is_e == SlotW'(StoreRows - 1)) ? '0 : is_e + SlotW'(1);
            full_q    <= full_e;
          end
        end else begin
          in_col_q  <= ic_inc[ColW-1:0];
          in_row_q  <= ir_e;
          in_slot_q <= is_e;
          full_q    <= full_e;
        end
      end
    end else if (cmd_i.load) begin
      if (emit_last) active_q <= 1'b0;
      if (oc_inc >= (ColW+1)'(w_img)) begin
        out_col_q <= '0;
        if (or_inc >= (RowW+1)'(h_img)) begin
          out_row_q  <= '0;
          out_slot_q <= '0;
        end else begin
          out_row_q  <= or_inc[RowW-1:0];
          out_slot_q <= (out_slot_q == SlotW'(StoreRows - 1)) ? '0 : out_slot_q + SlotW'(1);
        end
      end else begin
        out_col_q <= oc_inc[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kr_q <= ir_e;
      kc_q <= ic_e;
    end
  end

  // is the output position due: in-position >= out-position + lag
  logic [ProdW-1:0] prod_k_q, prod_o_q, lag_q;
  logic [LinW-1:0]  k_lin, o_lin;

  always_ff @(posedge clk_i) begin
    prod_k_q <= ProdW'(kr_q) * ProdW'(w_img);
    prod_o_q <= ProdW'(out_row_q) * ProdW'(w_img);
    lag_q    <= ProdW'(down) * ProdW'(w_img) + ProdW'(right);
  end

  assign k_lin = LinW'(prod_k_q) + LinW'(kc_q);
  assign o_lin = LinW'(prod_o_q) + LinW'(out_col_q) + LinW'(lag_q);

  // window walk
  logic [WwW-1:0]      fx_q;
  logic [WhW-1:0]      fy_q;
  logic [SlotW-1:0]    slot_q, slot_init;
  logic [2:0]          bit_q;
  logic [PixW-1:0]     pref_q, quo_q, rdata_q, cand;
  logic [NW-1:0]       cnt_q, cnt_fin;
  logic [SumW-1:0]     sum_q, sum_fin, rem_q, dvs;
  logic                rdv_q, lt;
  logic signed [RsW-1:0] raw0, raw_next;
  logic signed [CsW-1:0] rawc;
  logic [ColW-1:0]     xx;
  logic [AddrW-1:0]    rd_addr, wr_addr;
  logic                walk_init, fx_wrap;

  assign raw0 = $signed({2'b00, out_row_q}) - $signed(RsW'(up));
  assign raw_next = raw0 + $signed(RsW'(fy_q)) + $signed(RsW'(1));

  always_comb begin
    if (raw0 < 0) slot_init = '0;
    else if (out_slot_q >= SlotW'(up)) slot_init = out_slot_q - SlotW'(up);
    else slot_init = SlotW'((SlotW+1)'(out_slot_q) + (SlotW+1)'(StoreRows) - (SlotW+1)'(up));
  end

  assign rawc = $signed({2'b00, out_col_q}) + $signed(CsW'(fx_q)) - $signed(CsW'(left));

  always_comb begin
    if (rawc < 0) xx = '0;
    else if (rawc > $signed({2'b00, w_img - ColW'(1)})) xx = w_img - ColW'(1);
    else xx = rawc[ColW-1:0];
  end

  assign rd_addr   = AddrW'(slot_q) * AddrW'(MAX_WIDTH) + AddrW'(xx);
  assign wr_addr   = AddrW'(is_e) * AddrW'(MAX_WIDTH) + AddrW'(ic_e);
  assign walk_init = cmd_i.start_scan || cmd_i.end_pass;
  assign fx_wrap   = (fx_q == w_win - WwW'(1));

  assign cand    = pref_q | (PixW'(1) << bit_q);
  assign lt      = rdv_q && (rdata_q < cand);
  assign cnt_fin = cnt_q + NW'(lt);
  assign sum_fin = sum_q + (rdv_q ? SumW'(rdata_q) : '0);
  assign dvs     = SumW'(n_win) << bit_q;

  logic [PixW-1:0] row_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && pix_go) begin
      row_mem[wr_addr] <= gray_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      rdata_q <= row_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
      bit_q <= '0;
    end else begin
      rdv_q <= cmd_i.scan_step;
      if (cmd_i.start_scan) begin
        bit_q <= 3'd7;
      end else if (cmd_i.end_pass) begin
        bit_q <= (mode_q == ModeAvg) ? 3'd7 : bit_q - 3'd1;
      end else if (cmd_i.div_step) begin
        bit_q <= bit_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_init) begin
      fx_q   <= '0;
      fy_q   <= '0;
      slot_q <= slot_init;
    end else if (cmd_i.scan_step) begin
      if (fx_wrap) begin
        fx_q <= '0;
        fy_q <= fy_q + WhW'(1);
        // step the stored row only while the window row is inside the frame
        if (raw_next >= $signed(RsW'(1)) && raw_next <= $signed({2'b00, h_img - RowW'(1)}))
        begin
          slot_q <= (slot_q == SlotW'(StoreRows - 1)) ? '0 : slot_q + SlotW'(1);
        end
      end else begin
        fx_q <= fx_q + WwW'(1);
      end
    end
    if (cmd_i.start_scan) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      pref_q <= '0;
    end else if (cmd_i.end_pass) begin
      cnt_q <= '0;
      sum_q <= sum_fin;
      if (cnt_fin <= kidx) pref_q <= cand;
      rem_q <= sum_fin;
      quo_q <= '0;
    end else begin
      cnt_q <= cnt_fin;
      sum_q <= sum_fin;
      if (cmd_i.div_step && rem_q >= dvs) begin
        rem_q        <= rem_q - dvs;
        quo_q[bit_q] <= 1'b1;
      end
    end
  end

  // output register
  logic            out_valid_q, out_last_q;
  logic [PixW-1:0] out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_value_q <= (mode_q == ModeAvg) ? quo_q : pref_q;
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  assign status_o.go_pix    = go_pix_q;
  assign status_o.go_flush  = go_flush_q;
  assign status_o.emit_ok   = k_lin >= o_lin;
  assign status_o.scan_last = fx_wrap && (fy_q == h_win - WhW'(1));
  assign status_o.bit_zero  = (bit_q == 3'd0);
  assign status_o.mode_avg  = (mode_q == ModeAvg);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmaf_pkg::*;

  localparam int StoreRows = MaxWinHDef + 1;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } pixel_out_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;  // [7:0] gray_value
  logic [1:0]          s_axis_tuser = '0;  // [0] item_kind, [1] frame_start
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;       // [7:0] filtered_value
  logic                m_axis_tlast;

  window_median_average_filter_core dut (.*);

  // predictor state
  logic [7:0]          line_store [StoreRows*MaxWidthDef];
  logic [ImgWRegW-1:0] img_w_reg = ImgWReset;
  logic [ImgHRegW-1:0] img_h_reg = ImgHReset;
  logic [WinWRegW-1:0] win_w_reg = WinWReset;
  logic [WinHRegW-1:0] win_h_reg = WinHReset;
  logic                mode_reg  = ModeMedian;
  int unsigned         in_col, in_row, out_col, out_row;
  bit                  frame_full, frame_open;
  bit                  same_cfg_done;

  pixel_out_t          expected_pixels [$];
  int                  send_idle_pct, recv_idle_pct;
  int                  failures, pixels_checked, requests_sent, frames_sent;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void filter_pixel(int unsigned iw, int unsigned ih,
                                       int unsigned ww, int unsigned wh);
    int         win [MaxWinWDef*MaxWinHDef];
    int         n, sum, v, j, yy, xx;
    pixel_out_t res;
    n = 0;
    sum = 0;
    for (int fy = 0; fy < wh; fy++) begin
      yy = clampi(int'(out_row) + fy - int'(wh / 2), 0, int'(ih) - 1);
      for (int fx = 0; fx < ww; fx++) begin
        xx = clampi(int'(out_col) + fx - int'(ww / 2), 0, int'(iw) - 1);
        win[n] = line_store[(yy % StoreRows) * MaxWidthDef + xx];
        sum += win[n];
        n++;
      end
    end
    if (mode_reg == ModeAvg) begin
      res.value = 8'(sum / n);
    end else begin
      for (int i = 1; i < n; i++) begin
        v = win[i];
        j = i;
        while (j > 0 && win[j-1] > v) begin
          win[j] = win[j-1];
          j--;
        end
        win[j] = v;
      end
      res.value = 8'(win[n/2]);
    end
    res.last = (out_row >= ih - 1) && (out_col >= iw - 1);
    out_col++;
    if (out_col >= iw) begin
      out_col = 0;
      out_row++;
      if (out_row >= ih) out_row = 0;
    end
    if (res.last) frame_open = 0;
    expected_pixels.push_back(res);
  endfunction

  function automatic void predict_request(bit kind, logic [7:0] gray, bit fs);
    int unsigned iw, ih, ww, wh, lag;
    longint unsigned k, o;
    iw = sat(img_w_reg, 1, MaxWidthDef);
    ih = sat(img_h_reg, 1, MaxHeight);
    ww = sat(win_w_reg, 1, MaxWinWDef);
    wh = sat(win_h_reg, 1, MaxWinHDef);
    lag = (wh - 1 - wh / 2) * iw + (ww - 1 - ww / 2);
    if (kind == KindFlush) begin
      if (frame_open && frame_full) filter_pixel(iw, ih, ww, wh);
      return;
    end
    if (fs) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_full = 0;
      frame_open = 1;
    end
    if (!frame_open || frame_full) return;
    k = longint'(in_row) * iw + in_col;
    o = longint'(out_row) * iw + out_col;
    line_store[(in_row % StoreRows) * MaxWidthDef + (in_col % MaxWidthDef)] = gray;
    in_col++;
    if (in_col >= iw) begin
      in_col = 0;
      in_row++;
      if (in_row >= ih) begin
        in_row = 0;
        frame_full = 1;
        same_cfg_done = 1;
      end
    end
    if (k >= o + lag) filter_pixel(iw, ih, ww, wh);
  endfunction

  task automatic send_request(bit kind, logic [7:0] gray, bit fs);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = gray;
    s_axis_tuser  = {fs, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(kind, gray, fs);
    requests_sent++;
  endtask

  // drain outputs, then allow for a request still in flight
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(wmaf_cfg_reg_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = CfgDataW'(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:   img_w_reg = ImgWRegW'(value);
      REG_IMAGE_HEIGHT:  img_h_reg = ImgHRegW'(value);
      REG_WINDOW_WIDTH:  win_w_reg = WinWRegW'(value);
      REG_WINDOW_HEIGHT: win_h_reg = WinHRegW'(value);
      default:           mode_reg  = value[0];
    endcase
    same_cfg_done = 0;
  endtask

  task automatic set_frame(int unsigned iw, int unsigned ih, int unsigned ww,
                           int unsigned wh, bit mode);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, iw);
    write_reg(REG_IMAGE_HEIGHT, ih);
    write_reg(REG_WINDOW_WIDTH, ww);
    write_reg(REG_WINDOW_HEIGHT, wh);
    write_reg(REG_FILTER_MODE, mode);
  endtask

  function automatic logic [7:0] pattern_pixel(int style, int idx);
    case (style)
      0:       return (idx % 2) ? 8'hFF : 8'h00;
      1:       return 8'(idx * 37);
      default: return 8'($urandom);
    endcase
  endfunction

  // send count pixels; drain with flushes unless cut short
  task automatic send_frame(int count, int style, bit drain);
    for (int i = 0; i < count; i++) begin
      send_request(KindPixel, pattern_pixel(style, i), i == 0);
      if ($urandom_range(99) < 3) send_request(KindFlush, 8'($urandom), 1'($urandom));
    end
    if (drain) begin
      while (frame_open && frame_full) send_request(KindFlush, 8'($urandom), 1'($urandom));
      frames_sent++;
    end
  endtask

  task automatic test_no_frame();
    send_request(KindPixel, 8'h5A, 1'b0);
    send_request(KindFlush, 8'h00, 1'b0);
  endtask

  task automatic test_single_pixel();
    set_frame(1, 1, 1, 1, ModeAvg);
    send_frame(1, 1, 1);
    // pixel after a complete frame, then a flush with nothing pending
    send_request(KindPixel, 8'hFF, 1'b0);
    send_request(KindFlush, 8'hFF, 1'b1);
  endtask

  task automatic test_window_extremes();
    set_frame(3, 2, 9, 5, ModeMedian);
    send_frame(6, 0, 1);
    set_frame(3, 2, 9, 5, ModeAvg);
    send_frame(6, 0, 1);
    set_frame(4, 3, 8, 4, ModeMedian);
    send_frame(12, 2, 1);
  endtask

  task automatic test_saturation();
    set_frame(0, 0, 0, 0, ModeMedian);
    send_frame(1, 2, 1);
    set_frame(2047, 1, 15, 1, ModeAvg);
    send_frame(MaxWidthDef, 2, 1);
    set_frame(5, 8191, 3, 7, ModeAvg);
    send_frame(12, 2, 0);
  endtask

  task automatic test_restart();
    set_frame(4, 3, 3, 3, ModeMedian);
    send_frame(12, 2, 1);
    send_frame(7, 2, 0);
    send_frame(12, 1, 1);
  endtask

  task automatic test_random(int requests);
    int start, iw, ih, ww, wh;
    start = requests_sent;
    while (requests_sent - start < requests) begin
      iw = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 12);
      ih = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(1, 6);
      ww = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 9);
      wh = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(1, 5);
      set_frame(iw, ih, ww, wh, 1'($urandom));
      iw = sat(iw, 1, MaxWidthDef);
      ih = sat(ih, 1, MaxHeight);
      repeat ($urandom_range(1, 3)) begin
        if (same_cfg_done && $urandom_range(3) == 0)
          send_frame($urandom_range(1, iw * ih), $urandom_range(2), 0);
        send_frame(iw * ih, $urandom_range(2), 1);
      end
      if ($urandom_range(4) == 0) begin
        send_request(KindPixel, 8'($urandom), 1'b0);
        send_request(KindFlush, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result value %0d last %0d", m_axis_tdata, m_axis_tlast);
        failures++;
      end else begin
        pixel_out_t exp_px;
        exp_px = expected_pixels.pop_front();
        if (m_axis_tdata !== exp_px.value) begin
          $error("filtered_value expected %0d actual %0d", exp_px.value, m_axis_tdata);
          failures++;
        end
        if (m_axis_tlast !== exp_px.last) begin
          $error("frame_last expected %0d actual %0d", exp_px.last, m_axis_tlast);
          failures++;
        end
        pixels_checked++;
      end
    end
  end

  initial begin
    foreach (line_store[i]) line_store[i] = 8'h00;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_no_frame();
    test_single_pixel();
    test_window_extremes();
    test_saturation();
    test_restart();
    send_idle_pct = 38; recv_idle_pct = 82;
    test_random(280);
    send_idle_pct = 82; recv_idle_pct = 38;
    test_random(280);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(280);
    wait_idle();
    repeat (400) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      $error("%0d results never arrived", expected_pixels.size());
      failures++;
    end
    $display("Sent %0d requests over %0d frames, checked %0d filtered pixels",
             requests_sent, frames_sent, pixels_checked);
    $display("Covered mean and median modes, border clamping and register saturation");
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
